>>> rtl/core/dmpk_pkg.sv
package dmpk_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 16;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 11;

    // cantor pairing arithmetic widths
    localparam int SUM_W  = KEY_W + 1;
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam int HASH_W = PROD_W - 1;
    localparam int STEP_W = $clog2(HASH_W);

    // apb register map
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = 2'd0;
    localparam logic [CFG_W-1:0]   TABLE_SIZE_RST  = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] km;
        logic [KEY_W-1:0] kn;
        logic [VAL_W-1:0] val;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_init;
        logic div_step;
        logic rd;
        logic commit;
        logic clr_wr;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic clr_last;
    } t_sts;

endpackage

>>> rtl/core/dmpk_req_if.sv
interface dmpk_req_if;
    import dmpk_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key_m;
    logic [KEY_W-1:0] key_n;
    logic [VAL_W-1:0] value;

    modport source (output valid, op, key_m, key_n, value, input ready);
    modport sink   (input valid, op, key_m, key_n, value, output ready);
endinterface

>>> rtl/core/dmpk_rsp_if.sv
interface dmpk_rsp_if;
    import dmpk_pkg::*;

    logic             valid;
    logic             ready;
    logic             hit;
    logic [KEY_W-1:0] out_key_m;
    logic [KEY_W-1:0] out_key_n;
    logic [VAL_W-1:0] out_value;

    modport source (output valid, hit, out_key_m, out_key_n, out_value, input ready);
    modport sink   (input valid, hit, out_key_m, out_key_n, out_value, output ready);
endinterface

>>> rtl/core/dmpk_ctrl.sv
module dmpk_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dmpk_pkg::t_cmd o_cmd,
    input  dmpk_pkg::t_sts i_sts
);
    import dmpk_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_INIT,
        ST_DIV,
        ST_READ,
        ST_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_RESP;
            end
            ST_RESP: begin
                o_cmd.commit = out_free;
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/dmpk_dp.sv
module dmpk_dp #(
    parameter int TABLE_DEPTH = dmpk_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dmpk_pkg::t_cmd              i_cmd,
    output dmpk_pkg::t_sts              o_sts,
    input  logic [dmpk_pkg::OP_W-1:0]   i_op,
    input  logic [dmpk_pkg::KEY_W-1:0]  i_key_m,
    input  logic [dmpk_pkg::KEY_W-1:0]  i_key_n,
    input  logic [dmpk_pkg::VAL_W-1:0]  i_value,
    input  logic                        i_cfg_we,
    input  logic [dmpk_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic [dmpk_pkg::CFG_W-1:0]  o_table_size,
    output logic                        o_hit,
    output logic [dmpk_pkg::KEY_W-1:0]  o_key_m,
    output logic [dmpk_pkg::KEY_W-1:0]  o_key_n,
    output logic [dmpk_pkg::VAL_W-1:0]  o_value
);
    import dmpk_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SZ_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (SZ_W > CFG_W) ? SZ_W : CFG_W;

    // captured item
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_km;
    logic [KEY_W-1:0] r_kn;
    logic [VAL_W-1:0] r_val;

    logic [CFG_W-1:0] r_tsize;
    logic [CW-1:0]    cfg_ext;
    logic [SZ_W-1:0]  size_eff;

    logic [SUM_W-1:0]  sum;
    logic [SUM_W:0]    sum_p1;
    logic [PROD_W-1:0] r_prod;

    logic [HASH_W-1:0] r_div;
    logic [SZ_W-1:0]   r_rem;
    logic [SZ_W:0]     trial;
    logic [SZ_W:0]     trial_sub;
    logic [STEP_W-1:0] r_step;
    logic [IDX_W-1:0]  slot;

    t_entry           r_mem [TABLE_DEPTH];
    t_entry           r_rd;
    logic [IDX_W-1:0] r_clr_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_entry           mem_wd;

    logic             match;
    logic             slot_we;
    t_entry           new_ent;
    logic             res_hit;
    logic [KEY_W-1:0] res_km;
    logic [KEY_W-1:0] res_kn;
    logic [VAL_W-1:0] res_val;

    logic             r_hit;
    logic [KEY_W-1:0] r_okm;
    logic [KEY_W-1:0] r_okn;
    logic [VAL_W-1:0] r_oval;

    // size in use: zero acts as one, saturate at the table depth
    assign cfg_ext = CW'(r_tsize);
    always_comb begin
        if (cfg_ext == '0) begin
            size_eff = SZ_W'(1);
        end else if (cfg_ext > CW'(TABLE_DEPTH)) begin
            size_eff = SZ_W'(TABLE_DEPTH);
        end else begin
            size_eff = SZ_W'(cfg_ext);
        end
    end

    assign sum    = SUM_W'(r_km) + SUM_W'(r_kn);
    assign sum_p1 = (SUM_W + 1)'(sum) + (SUM_W + 1)'(1);

    // one remainder bit per step
    assign trial     = {r_rem, r_div[HASH_W-1]};
    assign trial_sub = trial - (SZ_W + 1)'(size_eff);
    assign slot      = r_rem[IDX_W-1:0];

    assign o_sts.div_last = (r_step == STEP_W'(HASH_W - 1));
    assign o_sts.clr_last = (r_clr_addr == IDX_W'(TABLE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsize    <= TABLE_SIZE_RST;
            r_clr_addr <= '0;
            r_step     <= '0;
        end else begin
            if (i_cfg_we) r_tsize <= i_cfg_wdata;
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (i_cmd.div_init) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_km  <= i_key_m;
            r_kn  <= i_key_n;
            r_val <= i_value;
        end
        if (i_cmd.mul) r_prod <= PROD_W'(sum) * PROD_W'(sum_p1);
        if (i_cmd.div_init) begin
            r_div <= r_prod[PROD_W-1:1] + HASH_W'(r_kn);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_div <= r_div << 1;
            if (trial >= (SZ_W + 1)'(size_eff)) begin
                r_rem <= SZ_W'(trial_sub);
            end else begin
                r_rem <= SZ_W'(trial);
            end
        end
    end

    // read-modify-write of the addressed slot
    always_comb begin
        match   = r_rd.vld && (r_rd.km == r_km) && (r_rd.kn == r_kn);
        res_hit = 1'b0;
        res_km  = '0;
        res_kn  = '0;
        res_val = '0;
        slot_we = 1'b0;
        new_ent = r_rd;
        unique case (r_op)
            OP_INSERT: begin
                slot_we     = 1'b1;
                new_ent.vld = 1'b1;
                new_ent.km  = r_km;
                new_ent.kn  = r_kn;
                new_ent.val = r_val;
                res_hit     = r_rd.vld;
                res_km      = r_rd.vld ? r_rd.km  : r_km;
                res_kn      = r_rd.vld ? r_rd.kn  : r_kn;
                res_val     = r_rd.vld ? r_rd.val : r_val;
            end
            OP_DELETE, OP_LOOKUP: begin
                if (match) begin
                    res_hit = 1'b1;
                    res_km  = r_rd.km;
                    res_kn  = r_rd.kn;
                    res_val = r_rd.val;
                    if (r_op == OP_DELETE) begin
                        slot_we     = 1'b1;
                        new_ent.vld = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign mem_we = i_cmd.clr_wr || (i_cmd.commit && slot_we);
    assign mem_wa = i_cmd.clr_wr ? r_clr_addr : slot;
    assign mem_wd = i_cmd.clr_wr ? t_entry'('0) : new_ent;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.rd) r_rd <= r_mem[slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit  <= res_hit;
            r_okm  <= res_km;
            r_okn  <= res_kn;
            r_oval <= res_val;
        end
    end

    assign o_table_size = r_tsize;
    assign o_hit        = r_hit;
    assign o_key_m      = r_okm;
    assign o_key_n      = r_okn;
    assign o_value      = r_oval;

endmodule

>>> rtl/core/direct_mapped_pair_key_table_unit.sv
// direct-mapped memo table keyed by a pair (key_m, key_n)
// request channel i_req: op (insert, delete, lookup), key pair and value
// response channel o_rsp: hit flag and the returned entry, one word per request
// config: apb-style port, register table_size at byte address 0 (slots in use)
// slot = cantor pairing of the key pair, modulo the size in use
// sequence: a response shows once its accepted request word has passed a multiply,
//   an add, the bit-serial remainder unit, a memory read and an update
// one request at a time: the remainder unit is shared and each slot
//   read-modify-write completes before the next request is taken
// reset: synchronous, active low; afterwards a clearing pass writes every
//   slot invalid, and during that pass i_req.ready stays low
//   (config writes are taken as usual); table_size returns to 1024
// stall: the response sits in an output register; the next request is
//   accepted while it waits, and only the final update waits for o_rsp.ready
// table_size may only change while no request is in flight
module direct_mapped_pair_key_table_unit #(
    parameter int TABLE_DEPTH = dmpk_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dmpk_req_if.sink                      i_req,
    dmpk_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dmpk_pkg::PADDR_W-1:0]  paddr,
    input  logic [dmpk_pkg::PDATA_W-1:0]  pwdata,
    output logic [dmpk_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import dmpk_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic             cfg_we;
    logic [CFG_W-1:0] table_size;

    // apb write in the access phase; no wait states
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == ADDR_TABLE_SIZE);
    assign prdata = (paddr == ADDR_TABLE_SIZE) ? PDATA_W'(table_size) : '0;

    // sequencing: clearing pass, then per request mul, add, divide, read, update
    dmpk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // hash arithmetic, slot memory and the response register
    dmpk_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_req.op),
        .i_key_m      (i_req.key_m),
        .i_key_n      (i_req.key_n),
        .i_value      (i_req.value),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (pwdata[CFG_W-1:0]),
        .o_table_size (table_size),
        .o_hit        (o_rsp.hit),
        .o_key_m      (o_rsp.out_key_m),
        .o_key_n      (o_rsp.out_key_n),
        .o_value      (o_rsp.out_value)
    );

endmodule

>>> rtl/core/dmpk_chk.sv
module dmpk_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic                         i_rsp_hit,
    input logic [dmpk_pkg::KEY_W-1:0]   i_rsp_key_m,
    input logic [dmpk_pkg::KEY_W-1:0]   i_rsp_key_n,
    input logic [dmpk_pkg::VAL_W-1:0]   i_rsp_value
);
    import dmpk_pkg::*;

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_hit)
            && $stable(i_rsp_key_m) && $stable(i_rsp_key_n) && $stable(i_rsp_value))
        else $error("response changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready ##1 !i_req_ready)
        else $error("request taken while another is in flight");

    // a new response only comes from an item already in flight
    a_rsp_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("response without a request in flight");

endmodule

bind direct_mapped_pair_key_table_unit dmpk_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_hit   (o_rsp.hit),
    .i_rsp_key_m (o_rsp.out_key_m),
    .i_rsp_key_n (o_rsp.out_key_n),
    .i_rsp_value (o_rsp.out_value)
);

>>> tb/sv/tb_direct_mapped_pair_key_table_unit.sv
`timescale 1ns / 100ps

module tb_direct_mapped_pair_key_table_unit;
    import dmpk_pkg::*;

    // op code that the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int BLOCK_LAT    = 40;
    localparam int WORDS_PER_PH = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] km;
        logic [KEY_W-1:0] kn;
        logic [VAL_W-1:0] val;
    } t_rsp_word;

    // software copy of the memo table; one awaited response word per request
    class memo_table_mirror;
        bit               used     [DEF_TABLE_DEPTH];
        logic [KEY_W-1:0] key_m_at [DEF_TABLE_DEPTH];
        logic [KEY_W-1:0] key_n_at [DEF_TABLE_DEPTH];
        logic [VAL_W-1:0] value_at [DEF_TABLE_DEPTH];
        logic [CFG_W-1:0] table_size;
        t_rsp_word        awaited  [$];
        int               errors;

        function new();
            table_size = TABLE_SIZE_RST;
            errors     = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function void set_size(logic [CFG_W-1:0] size);
            table_size = size;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // cantor pairing of the key pair, modulo the slots in use
        function int unsigned slot_of_pair(logic [KEY_W-1:0] m, logic [KEY_W-1:0] n);
            longint unsigned sum;
            longint unsigned pairing;
            longint unsigned span;
            sum     = longint'(m) + longint'(n);
            pairing = ((sum + 1) * sum) / 2 + longint'(n);
            if (table_size == 0)
                span = 1;
            else if (table_size > DEF_TABLE_DEPTH)
                span = DEF_TABLE_DEPTH;
            else
                span = table_size;
            return int'(pairing % span);
        endfunction

        function void take_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] km,
                                   logic [KEY_W-1:0] kn, logic [VAL_W-1:0] val);
            int unsigned slot;
            bit          same_key;
            t_rsp_word   want;
            slot     = slot_of_pair(km, kn);
            same_key = used[slot] && key_m_at[slot] == km && key_n_at[slot] == kn;
            want     = '0;
            if (op == OP_INSERT) begin
                if (used[slot])
                    want = {1'b1, key_m_at[slot], key_n_at[slot], value_at[slot]};
                else
                    want = {1'b0, km, kn, val};
                used[slot]     = 1'b1;
                key_m_at[slot] = km;
                key_n_at[slot] = kn;
                value_at[slot] = val;
            end else if (op == OP_DELETE || op == OP_LOOKUP) begin
                if (same_key) begin
                    want = {1'b1, key_m_at[slot], key_n_at[slot], value_at[slot]};
                    if (op == OP_DELETE) used[slot] = 1'b0;
                end
            end
            awaited.push_back(want);
        endfunction

        function void match_response(t_rsp_word got);
            t_rsp_word want;
            if (awaited.size() == 0) begin
                $error("response word with nothing awaited: hit %0d key (%0h,%0h) value %0h",
                       got.hit, got.km, got.kn, got.val);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.km !== want.km) begin
                $error("out_key_m: expected %0h, got %0h", want.km, got.km);
                errors++;
            end
            if (got.kn !== want.kn) begin
                $error("out_key_n: expected %0h, got %0h", want.kn, got.kn);
                errors++;
            end
            if (got.val !== want.val) begin
                $error("out_value: expected %0h, got %0h", want.val, got.val);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    dmpk_req_if req_if ();
    dmpk_rsp_if rsp_if ();

    direct_mapped_pair_key_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    memo_table_mirror sb = new();

    // calm: no idling on either side; hold_wanted: receiver starts a long hold-off
    bit          calm;
    bit          hold_wanted;
    int unsigned cycle_cnt = 0;
    logic [31:0] key_pool [$];
    t_rsp_word   rsp_seen;

    // table sizes per random phase: tiny, zero, odd, saturating, full, small
    int unsigned size_plan [10] = '{1, 0, 7, 2047, 1500, 64, 1024, 3, 2, 1023};

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL direct_mapped_pair_key_table_unit");
            $finish;
        end
    end

    // response monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_seen = {rsp_if.hit, rsp_if.out_key_m, rsp_if.out_key_n, rsp_if.out_value};
            sb.match_response(rsp_seen);
        end
    end

    // receiver: random stalls, a calm stretch, and one long hold-off on request
    initial begin : rsp_side
        int hold_left;
        bit hold_taken;
        hold_left    = 0;
        hold_taken   = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_wanted && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= 22);
            end
        end
    end

    // offer one request word, possibly after a gap, and wait for acceptance
    task automatic send_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] km,
                             logic [KEY_W-1:0] kn, logic [VAL_W-1:0] val);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 22) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.key_m <= km;
        req_if.key_n <= kn;
        req_if.value <= val;
        do @(posedge i_clk); while (!req_if.ready);
        sb.take_request(op, km, kn, val);
    endtask

    // two-phase register write, only while the block is idle
    task automatic write_table_size(logic [CFG_W-1:0] size);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TABLE_SIZE;
        pwdata  <= PDATA_W'(size);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_size(size);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid, wait for every awaited word, then let the pipeline go quiet
    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (BLOCK_LAT) @(posedge i_clk);
    endtask

    // mostly keys already in play so that hits and displacements happen
    task automatic random_word();
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] km;
        logic [KEY_W-1:0] kn;
        logic [31:0]      pair;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 40)      op = OP_INSERT;
        else if (pick < 65) op = OP_LOOKUP;
        else if (pick < 88) op = OP_DELETE;
        else                op = OP_SPARE;
        pick = $urandom_range(99);
        if (key_pool.size() != 0 && pick < 65) begin
            pair = key_pool[$urandom_range(key_pool.size() - 1)];
        end else if (pick < 82) begin
            pair = {16'($urandom_range(31)), 16'($urandom_range(31))};
        end else begin
            pair = $urandom;
        end
        km = pair[31:16];
        kn = pair[15:0];
        if (op == OP_INSERT) begin
            key_pool.push_back(pair);
            if (key_pool.size() > 12) void'(key_pool.pop_front());
        end
        send_word(op, km, kn, $urandom);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_if.valid = 1'b0;
        req_if.op    = '0;
        req_if.key_m = '0;
        req_if.key_n = '0;
        req_if.value = '0;
        calm         = 1'b0;
        hold_wanted  = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed at the reset size: empty insert, overwrite, hit and miss paths
        send_word(OP_INSERT, 16'h0000, 16'h0000, 32'h0000_0000);
        send_word(OP_INSERT, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_word(OP_LOOKUP, 16'h0000, 16'h0000, 32'h0);
        send_word(OP_LOOKUP, 16'h0001, 16'h0000, 32'h0);
        send_word(OP_DELETE, 16'h0000, 16'h0000, 32'h0);
        send_word(OP_DELETE, 16'h0000, 16'h0000, 32'h0);
        send_word(OP_LOOKUP, 16'h0000, 16'h0000, 32'h0);
        // key extremes and the unused op code
        send_word(OP_INSERT, 16'hFFFF, 16'hFFFF, 32'hA5A5_A5A5);
        send_word(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 32'h0);
        send_word(OP_SPARE,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 32'h0);
        send_word(OP_INSERT, 16'hFFFF, 16'h0000, 32'h5A5A_5A5A);
        send_word(OP_INSERT, 16'h0000, 16'hFFFF, 32'h0000_0001);
        settle();

        // one slot: different key on the same slot misses, insert displaces
        write_table_size(CFG_W'(1));
        send_word(OP_INSERT, 16'h0001, 16'h0002, 32'h0000_0011);
        send_word(OP_LOOKUP, 16'h0002, 16'h0001, 32'h0);
        send_word(OP_DELETE, 16'h0002, 16'h0001, 32'h0);
        send_word(OP_INSERT, 16'h0002, 16'h0001, 32'h0000_0022);
        send_word(OP_DELETE, 16'h0002, 16'h0001, 32'h0);
        send_word(OP_LOOKUP, 16'h0002, 16'h0001, 32'h0);

        // random phases over several table sizes; the table is never cleared
        for (int p = 0; p < 10; p++) begin
            if (p > 0) begin
                settle();
                write_table_size(CFG_W'(size_plan[p]));
            end
            calm = (p == 6);
            // receiver stalls long enough for the block to back up its input
            if (p == 3) hold_wanted = 1'b1;
            for (int k = 0; k < WORDS_PER_PH; k++) random_word();
        end
        calm = 1'b0;

        settle();
        if (sb.errors == 0) begin
            $display("PASS direct_mapped_pair_key_table_unit");
        end else begin
            $display("FAIL direct_mapped_pair_key_table_unit");
        end
        $finish;
    end

endmodule
